FILE: hw/rtl/shared_bank_pool_lru_binder_unit_assert.svh
// Assertion macros used by the port checker of the bank pool binder.
`ifndef SHARED_BANK_POOL_LRU_BINDER_UNIT_ASSERT_SVH
`define SHARED_BANK_POOL_LRU_BINDER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SBP_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sbp port check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SBP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sbp port check failed");

`endif

FILE: hw/rtl/sbp_pkg.sv
// Shared constants, codes and types of the bank pool binder.
package sbp_pkg;

   localparam int POOL_SIZE   = 16;
   localparam int TICK_WIDTH  = 32;
   localparam int IDX_W       = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int SET_W       = 8;
   localparam int BANK_W      = 16;
   localparam int IDENT_W     = 15;
   localparam int MASK_W      = 16;
   localparam int KIND_W      = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;

   // bank id -1: no bank / pool not created
   localparam logic [BANK_W-1:0] NO_BANK = {BANK_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_BIND_ANY  = 3'd0,
      KIND_BIND_SPEC = 3'd1,
      KIND_RELEASE   = 3'd2,
      KIND_LOOKUP    = 3'd3,
      KIND_CLEAR     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // search word that walks down the row of cells, one cell per cycle
   typedef struct packed {
      logic                  valid;
      logic                  free_hit;
      logic [IDX_W-1:0]      free_idx;
      logic                  lru_hit;
      logic [IDX_W-1:0]      lru_idx;
      logic [TICK_WIDTH-1:0] lru_stamp;
      logic [SET_W-1:0]      lru_owner;
      logic                  tgt_bound;
      logic [SET_W-1:0]      tgt_owner;
   } word_type;

   // update broadcast to all cells at the end of an operation
   typedef struct packed {
      logic                  en;
      logic                  clear;
      logic                  bind_en;
      logic                  stamp_en;
      logic [IDX_W-1:0]      idx;
      logic [SET_W-1:0]      owner;
      logic [TICK_WIDTH-1:0] stamp;
   } commit_type;

endpackage

FILE: hw/rtl/sbp_cell.sv
// One pool entry: binding state plus one stage of the search chain.
module sbp_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sbp_pkg::IDX_W-1:0]           cell_idx,
   input  logic                                mapped_bit,
   input  logic [sbp_pkg::IDX_W-1:0]           tgt_idx,
   input  sbp_pkg::word_type                   word_prev,
   input  sbp_pkg::commit_type                 commit,
   output sbp_pkg::word_type                   word_out
);

   logic                            bound_ff;
   logic [sbp_pkg::SET_W-1:0]       owner_ff;
   logic [sbp_pkg::TICK_WIDTH-1:0]  last_use_ff;
   sbp_pkg::word_type               word_ff;
   sbp_pkg::word_type               word_in;

   // fold this entry into the passing word
   always_comb begin
      sbp_pkg::word_type w;
      w = word_prev;
      // first unbound entry wins
      if (!bound_ff && !w.free_hit) begin
         w.free_hit = 1'b1;
         w.free_idx = cell_idx;
      end
      // oldest unmapped entry, strict compare keeps the lower index on ties
      if (!mapped_bit && (!w.lru_hit || (last_use_ff < w.lru_stamp))) begin
         w.lru_hit   = 1'b1;
         w.lru_idx   = cell_idx;
         w.lru_stamp = last_use_ff;
         w.lru_owner = owner_ff;
      end
      // named entry reports its binding
      if (cell_idx == tgt_idx) begin
         w.tgt_bound = bound_ff;
         w.tgt_owner = owner_ff;
      end
      word_in = w;
   end

   // chain stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff <= word_in;
      end
   end

   // entry state update
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff    <= 1'b0;
         owner_ff    <= '0;
         last_use_ff <= '0;
      end else if (commit.en && commit.clear) begin
         bound_ff    <= 1'b0;
         owner_ff    <= '0;
         last_use_ff <= '0;
      end else if (commit.en && (commit.idx == cell_idx)) begin
         if (commit.bind_en) begin
            bound_ff <= 1'b1;
            owner_ff <= commit.owner;
         end
         if (commit.stamp_en) begin
            last_use_ff <= commit.stamp;
         end
      end
   end

   assign word_out = word_ff;

endmodule

FILE: hw/rtl/sbp_ctrl.sv
// Sequencer: request capture, result decision, use counter and output register.
module sbp_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   // request beats
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] requester_set, [22:8] bank_ident, [38:23] mapped_mask
   input  logic [sbp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] kind
   input  logic [sbp_pkg::KIND_W-1:0]          req_tuser,
   // response beats
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] ok, [16:1] granted_bank, [17] warm, [18] detached, [26:19] other_set
   output logic [sbp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // pool_first_bank register
   input  logic                                csr_wen,
   input  logic signed [sbp_pkg::BANK_W-1:0]   csr_wdata,
   // cell row
   input  sbp_pkg::word_type                   chain_word,
   output sbp_pkg::word_type                   inject,
   output sbp_pkg::commit_type                 commit,
   output logic [sbp_pkg::IDX_W-1:0]           tgt_idx,
   output logic [sbp_pkg::MASK_W-1:0]          mapped_mask
);

   sbp_pkg::state_type               state_ff, state_in;
   logic signed [sbp_pkg::BANK_W-1:0] first_ff;
   sbp_pkg::kind_type                kind_ff;
   logic [sbp_pkg::SET_W-1:0]        set_ff;
   logic                             hit_ff, hit_in;
   logic [sbp_pkg::IDX_W-1:0]        tgt_idx_ff, tgt_idx_in;
   logic [sbp_pkg::MASK_W-1:0]       mask_ff;
   sbp_pkg::word_type                inject_ff, inject_in;
   sbp_pkg::word_type                fin_ff;
   logic [sbp_pkg::TICK_WIDTH-1:0]   tick_ff, tick_in;
   logic                             rsp_valid_ff;
   logic [sbp_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                             accept;
   logic                             commit_go;
   logic                             latch_fin;
   logic [sbp_pkg::IDENT_W-1:0]      in_ident;
   logic [sbp_pkg::BANK_W-1:0]       diff;

   // decision outputs
   logic                             r_ok;
   logic [sbp_pkg::BANK_W-1:0]       r_bank;
   logic                             r_warm;
   logic                             r_detached;
   logic [sbp_pkg::SET_W-1:0]        r_other;
   sbp_pkg::commit_type              c_next;

   assign accept   = req_tvalid && req_tready;
   assign in_ident = req_tdata[22:8];

   // pool range check of the named bank id
   assign diff       = {1'b0, in_ident} - {1'b0, first_ff[sbp_pkg::IDENT_W-1:0]};
   assign hit_in     = !first_ff[sbp_pkg::BANK_W-1]
                       && (in_ident >= first_ff[sbp_pkg::IDENT_W-1:0])
                       && (diff < sbp_pkg::BANK_W'(sbp_pkg::POOL_SIZE));
   assign tgt_idx_in = diff[sbp_pkg::IDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbp_pkg::ST_IDLE: if (accept) state_in = sbp_pkg::ST_SCAN;
         sbp_pkg::ST_SCAN: if (chain_word.valid) state_in = sbp_pkg::ST_DONE;
         sbp_pkg::ST_DONE: if (!rsp_valid_ff || rsp_tready) state_in = sbp_pkg::ST_IDLE;
         default:          state_in = sbp_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      latch_fin  = 1'b0;
      commit_go  = 1'b0;
      case (state_ff)
         sbp_pkg::ST_IDLE: req_tready = 1'b1;
         sbp_pkg::ST_SCAN: latch_fin  = chain_word.valid;
         sbp_pkg::ST_DONE: commit_go  = !rsp_valid_ff || rsp_tready;
         default:          req_tready = 1'b0;
      endcase
   end

   // fresh search word, valid for one cycle after a request beat
   always_comb begin
      inject_in       = '0;
      inject_in.valid = accept;
   end

   // result and state update from the finished search word
   always_comb begin
      logic                        sel_ok;
      logic [sbp_pkg::IDX_W-1:0]   sel_idx;
      logic                        sel_bound;
      logic [sbp_pkg::SET_W-1:0]   sel_owner;
      logic                        is_bind;
      logic [sbp_pkg::TICK_WIDTH-1:0] tick_inc;

      tick_inc   = tick_ff + sbp_pkg::TICK_WIDTH'(1);
      sel_ok     = 1'b0;
      sel_idx    = tgt_idx_ff;
      sel_bound  = fin_ff.tgt_bound;
      sel_owner  = fin_ff.tgt_owner;
      is_bind    = 1'b0;
      r_ok       = 1'b0;
      r_bank     = sbp_pkg::NO_BANK;
      r_warm     = 1'b0;
      r_detached = 1'b0;
      r_other    = '0;
      c_next     = '0;
      tick_in    = tick_ff;

      case (kind_ff)
         sbp_pkg::KIND_BIND_ANY: begin
            is_bind = 1'b1;
            if (!first_ff[sbp_pkg::BANK_W-1]) begin
               if (fin_ff.free_hit) begin
                  sel_ok    = 1'b1;
                  sel_idx   = fin_ff.free_idx;
                  sel_bound = 1'b0;
               end else if (fin_ff.lru_hit) begin
                  sel_ok    = 1'b1;
                  sel_idx   = fin_ff.lru_idx;
                  sel_bound = 1'b1;
                  sel_owner = fin_ff.lru_owner;
               end
            end
         end
         sbp_pkg::KIND_BIND_SPEC: begin
            is_bind = 1'b1;
            sel_ok  = hit_ff;
         end
         sbp_pkg::KIND_RELEASE: begin
            if (hit_ff) begin
               r_ok            = 1'b1;
               c_next.stamp_en = 1'b1;
               c_next.idx      = tgt_idx_ff;
               c_next.stamp    = tick_inc;
               tick_in         = tick_inc;
            end
         end
         sbp_pkg::KIND_LOOKUP: begin
            if (hit_ff && fin_ff.tgt_bound) begin
               r_ok    = 1'b1;
               r_other = fin_ff.tgt_owner;
            end
         end
         sbp_pkg::KIND_CLEAR: begin
            r_ok         = 1'b1;
            c_next.clear = 1'b1;
            tick_in      = '0;
         end
         default: r_ok = 1'b0;
      endcase

      // both bind kinds end the same way
      if (is_bind && sel_ok) begin
         r_ok            = 1'b1;
         r_bank          = first_ff + sbp_pkg::BANK_W'(sel_idx);
         r_warm          = sel_bound && (sel_owner == set_ff);
         r_detached      = sel_bound && (sel_owner != set_ff);
         r_other         = r_detached ? sel_owner : '0;
         c_next.bind_en  = 1'b1;
         c_next.stamp_en = 1'b1;
         c_next.idx      = sel_idx;
         c_next.owner    = set_ff;
         c_next.stamp    = tick_inc;
         tick_in         = tick_inc;
      end

      c_next.en = commit_go;
   end

   assign rsp_data_in = {5'b0, r_other, r_detached, r_warm, r_bank, r_ok};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbp_pkg::ST_IDLE;
         first_ff     <= '1;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         inject_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) first_ff <= csr_wdata;
         if (commit_go) tick_ff <= tick_in;
         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         inject_ff <= inject_in;
      end
   end

   // request capture, search result and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= sbp_pkg::kind_type'(req_tuser);
         set_ff     <= req_tdata[7:0];
         mask_ff    <= req_tdata[38:23];
         hit_ff     <= hit_in;
         tgt_idx_ff <= tgt_idx_in;
      end
      if (latch_fin) fin_ff <= chain_word;
      if (commit_go) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign inject      = inject_ff;
   assign commit      = c_next;
   assign tgt_idx     = tgt_idx_ff;
   assign mapped_mask = mask_ff;

endmodule

FILE: hw/rtl/shared_bank_pool_lru_binder_unit.sv
// Top level of the shared bank pool binder: sequencer plus a row of entry cells.
//
// One request beat is taken at a time. A search word enters the first entry cell the
// cycle after the request is accepted and moves one cell per cycle down the row of
// POOL_SIZE cells, picking up the first unbound entry, the least recently used
// unmapped entry and the binding of the named entry on the way. The finished word is
// latched, the result is decided from it and registered as the response, and the
// next request is taken as soon as the response is registered; a response still
// waiting in the output register holds back only the following result, not the
// next request. The pool_first_bank register resets to -1 (no pool); the user must
// write it only while idle, and the block itself does not enforce this.
module shared_bank_pool_lru_binder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] requester_set, [22:8] bank_ident, [38:23] mapped_mask
   input  logic [sbp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] kind
   input  logic [sbp_pkg::KIND_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] ok, [16:1] granted_bank, [17] warm, [18] detached, [26:19] other_set
   output logic [sbp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic signed [sbp_pkg::BANK_W-1:0]   csr_wdata
);

   sbp_pkg::word_type                 chain [sbp_pkg::POOL_SIZE+1];
   sbp_pkg::commit_type               commit;
   logic [sbp_pkg::IDX_W-1:0]         tgt_idx;
   logic [sbp_pkg::MASK_W-1:0]        mapped_mask;

   sbp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .chain_word  (chain[sbp_pkg::POOL_SIZE]),
      .inject      (chain[0]),
      .commit      (commit),
      .tgt_idx     (tgt_idx),
      .mapped_mask (mapped_mask)
   );

   // row of entry cells; entries past the mask width count as unmapped
   for (genvar i = 0; i < sbp_pkg::POOL_SIZE; i++) begin : g_cell
      logic mapped_bit;
      if (i < sbp_pkg::MASK_W) begin : g_masked
         assign mapped_bit = mapped_mask[i];
      end else begin : g_unmasked
         assign mapped_bit = 1'b0;
      end

      sbp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (sbp_pkg::IDX_W'(i)),
         .mapped_bit (mapped_bit),
         .tgt_idx    (tgt_idx),
         .word_prev  (chain[i]),
         .commit     (commit),
         .word_out   (chain[i+1])
      );
   end

endmodule

FILE: hw/rtl/sbp_port_checker.sv
// Port-level checker for the bank pool binder and its bind statement.
`include "shared_bank_pool_lru_binder_unit_assert.svh"

module sbp_port_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sbp_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   // response fields
   logic                        rsp_ok;
   logic [sbp_pkg::BANK_W-1:0]  rsp_bank;
   logic                        rsp_warm;
   logic                        rsp_detached;

   assign rsp_ok       = rsp_tdata[0];
   assign rsp_bank     = rsp_tdata[16:1];
   assign rsp_warm     = rsp_tdata[17];
   assign rsp_detached = rsp_tdata[18];

   // a stalled response beat stays offered
   `SBP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // only one request in flight: ready drops right after a request beat
   `SBP_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)

   // a failed operation never names a bank
   `SBP_ASSERT_NOW(a_fail_no_bank, rsp_tvalid && !rsp_ok, rsp_bank == sbp_pkg::NO_BANK)

   // warm rebind and detach exclude each other, and both need success
   `SBP_ASSERT_NOW(a_warm_detach, rsp_tvalid && (rsp_warm || rsp_detached), rsp_ok && !(rsp_warm && rsp_detached))

endmodule

bind shared_bank_pool_lru_binder_unit sbp_port_checker u_sbp_port_checker (.*);
